// ----- rtl/pss_pkg.sv -----
// pss_pkg: shared sizes, opcode/status codes and the cell command bundle
// for the positional sequence store. No dependencies.
`default_nettype none

package pss_pkg;

   localparam int CAPACITY = 64;
   localparam int ELEM_W   = 32;                       // stored element width
   localparam int DATA_W   = 32;                       // value / read_value ports
   localparam int POS_W    = 7;                        // position / count ports
   localparam int CNT_W    = $clog2(CAPACITY + 1);     // count register
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int GRP_SZ   = 8;                        // taps per gather group
   localparam int NGRP     = (CAPACITY + GRP_SZ - 1) / GRP_SZ;

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_POS   = 3'd2,
      OP_REM_FRONT = 3'd3,
      OP_REM_BACK  = 3'd4,
      OP_REM_POS   = 3'd5,
      OP_READ      = 3'd6,
      OP_WRITE     = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_WRITE  = 2'd3
   } cell_op_type;

   // Broadcast to every cell on the cycle a request is accepted.
   typedef struct packed {
      logic                accept;
      cell_op_type         op;
      logic [CMP_W-1:0]    pos;
      logic [ELEM_W-1:0]   value;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/pss_cell.sv -----
// pss_cell: one storage slot of the sequence, shifts with its neighbors.
// Depends on pss_pkg.
`default_nettype none

module pss_cell
   import pss_pkg::*;
(
   input  wire logic                clock,
   input  wire cell_cmd_type        cmd,
   input  wire logic [CMP_W-1:0]    index,
   input  wire logic [ELEM_W-1:0]   left_data,   // from slot index-1
   input  wire logic [ELEM_W-1:0]   right_data,  // from slot index+1
   output      logic [ELEM_W-1:0]   data,
   output      logic [ELEM_W-1:0]   tap          // old data if index matched
);

   logic [ELEM_W-1:0] data_ff, data_in;
   logic [ELEM_W-1:0] tap_ff;
   logic              hit;

   assign hit = (index == cmd.pos);

   always_comb begin
      unique case (cmd.op)
         CELL_HOLD:   data_in = data_ff;
         CELL_INSERT: data_in = (index > cmd.pos) ? left_data :
                                (hit ? cmd.value : data_ff);
         CELL_REMOVE: data_in = (index >= cmd.pos) ? right_data : data_ff;
         CELL_WRITE:  data_in = hit ? cmd.value : data_ff;
         default:     data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         tap_ff  <= hit ? data_ff : '0;
         data_ff <= data_in;
      end
   end

   assign data = data_ff;
   assign tap  = tap_ff;

endmodule

`default_nettype wire

// ----- rtl/pss_gather.sv -----
// pss_gather: registered OR tree that collects the one non-zero cell tap.
// Depends on pss_pkg.
`default_nettype none

module pss_gather
   import pss_pkg::*;
(
   input  wire logic                            clock,
   input  wire logic [CAPACITY-1:0][ELEM_W-1:0] taps,
   output      logic [ELEM_W-1:0]               result
);

   logic [NGRP-1:0][ELEM_W-1:0] group_ff, group_in;

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GRP_SZ; k++) begin
            if (g * GRP_SZ + k < CAPACITY)
               group_in[g] = group_in[g] | taps[g * GRP_SZ + k];
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   always_comb begin
      result = '0;
      for (int g = 0; g < NGRP; g++)
         result = result | group_ff[g];
   end

endmodule

`default_nettype wire

// ----- rtl/positional_sequence_store_unit.sv -----
// positional_sequence_store_unit: ordered list with insert/remove/read/write.
// Depends on pss_pkg, pss_cell and pss_gather.
//
// The list lives in a row of CAPACITY cells, slot i holding element i. On the
// cycle a request is accepted every cell compares its own index with the
// effective position and in one step shifts up (insert), shifts down (remove),
// loads the value (write) or holds, so the whole list is updated at the
// accept edge. At the same edge each cell latches its old contents into a tap
// if its index matches the position; a two-level OR tree (groups of eight,
// registered) then gathers the read data. The group register loads after the
// accept and the response register after the group register, so a response
// passes through the tap, group and response registers. The input is stalled
// from the accept until the response register loads, so no new request is
// taken while one is in flight; a finished response may sit in the output
// register while the next request is taken, and only when that next result is
// ready and the old response is still unclaimed does the input stay stalled
// longer. status: 0 ok, 1 full on insert, 2 empty on remove,
// 3 position out of range; on any error the list is unchanged and read_value
// is zero. Inserting into an empty list puts the element first regardless of
// position. No clearing pass: slots at or beyond the count are never read.
`default_nettype none

module positional_sequence_store_unit
   import pss_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [2:0]         req_opcode,
   input  wire logic [POS_W-1:0]   req_position,
   input  wire logic [DATA_W-1:0]  req_value,
   // response channel
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [DATA_W-1:0]  rsp_read_value,
   output      logic [POS_W-1:0]   rsp_count,
   output      logic               rsp_is_empty,
   output      logic [1:0]         rsp_status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_TAP,     // taps captured, group ORs loading
      S_GROUP    // group ORs valid, response can load
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   status_type       status_ff, status_in;
   logic             rd_ok_ff, rd_ok_in;

   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  rsp_read_value_ff;
   logic [POS_W-1:0]   rsp_count_ff;
   logic               rsp_is_empty_ff;
   status_type         rsp_status_ff;

   logic         req_accept, rsp_accept, rsp_load;
   cell_cmd_type cmd;
   opcode_type   opc;
   logic [CMP_W-1:0] pos_ext, cnt_ext, eff_pos;
   logic         is_full, is_zero;

   logic [CAPACITY-1:0][ELEM_W-1:0] cell_data;
   logic [CAPACITY-1:0][ELEM_W-1:0] cell_tap;
   logic [ELEM_W-1:0]               gathered;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign rsp_load   = (state_ff == S_GROUP) && (!rsp_valid_ff || !rsp_stall);

   assign opc     = opcode_type'(req_opcode);
   assign pos_ext = CMP_W'(req_position);
   assign cnt_ext = CMP_W'(count_ff);
   assign is_full = (count_ff >= CNT_W'(CAPACITY));
   assign is_zero = (count_ff == '0);

   // Decode: effective position, cell operation, status and next count.
   always_comb begin
      eff_pos    = pos_ext;
      cmd.accept = req_accept;
      cmd.op     = CELL_HOLD;
      cmd.value  = ELEM_W'(req_value);
      status_in  = ST_OK;
      count_in   = count_ff;
      rd_ok_in   = 1'b0;
      unique case (opc)
         OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
            if (opc == OP_INS_FRONT || is_zero)
               eff_pos = '0;
            else if (opc == OP_INS_BACK)
               eff_pos = cnt_ext;
            if (is_full)
               status_in = ST_FULL;
            else if (eff_pos > cnt_ext)
               status_in = ST_RANGE;
            else begin
               cmd.op   = CELL_INSERT;
               count_in = CNT_W'(count_ff + 1'b1);
            end
         end
         OP_REM_FRONT, OP_REM_BACK, OP_REM_POS: begin
            if (opc == OP_REM_FRONT)
               eff_pos = '0;
            else if (opc == OP_REM_BACK)
               eff_pos = CMP_W'(cnt_ext - 1'b1);
            if (is_zero)
               status_in = ST_EMPTY;
            else if (eff_pos >= cnt_ext)
               status_in = ST_RANGE;
            else begin
               cmd.op   = CELL_REMOVE;
               count_in = CNT_W'(count_ff - 1'b1);
            end
         end
         OP_READ, OP_WRITE: begin
            if (pos_ext >= cnt_ext)
               status_in = ST_RANGE;
            else if (opc == OP_WRITE)
               cmd.op = CELL_WRITE;
            else
               rd_ok_in = 1'b1;
         end
         default: status_in = ST_OK;
      endcase
      cmd.pos = eff_pos;
   end

   // Row of cells; the ends see zero neighbors.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEM_W-1:0] left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
      end
      pss_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .index      (CMP_W'(i)),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i]),
         .tap        (cell_tap[i])
      );
   end

   pss_gather u_gather (
      .clock  (clock),
      .taps   (cell_tap),
      .result (gathered)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_accept) state_in = S_TAP;
         S_TAP:   state_in = S_GROUP;
         S_GROUP: if (rsp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            count_ff  <= count_in;
            status_ff <= status_in;
            rd_ok_ff  <= rd_ok_in;
         end
         if (rsp_load) begin
            rsp_valid_ff      <= 1'b1;
            rsp_read_value_ff <= rd_ok_ff ? DATA_W'(gathered) : '0;
            rsp_count_ff      <= POS_W'(count_ff);
            rsp_is_empty_ff   <= (count_ff == '0);
            rsp_status_ff     <= status_ff;
         end else if (rsp_accept) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_is_empty   = rsp_is_empty_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count above capacity");

   a_accept_tap: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_TAP))
      else $error("accepted request did not enter tap stage");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && cmd.op == CELL_INSERT) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("insert did not bump count");

   a_err_hold: assert property (@(posedge clock) disable iff (reset)
      (req_accept && status_in != ST_OK) |=> $stable(count_ff))
      else $error("failed request changed count");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_is_empty_ff == (rsp_count_ff == '0)))
      else $error("is_empty disagrees with count");
`endif

endmodule

`default_nettype wire
